// ===== src/kmds_pkg.sv =====
// Package for the key matrix debounce scanner: field widths, parameter
// defaults, register indexes, controller states and inter-module structs.
// No dependencies.
package kmds_pkg;

  localparam int ROWS_MAX_D   = 8;
  localparam int COLS_MAX_D   = 8;
  localparam int LAYERS_MAX_D = 16;

  localparam int ROW_W    = 3;
  localparam int COLBIT_W = 8;
  localparam int TIME_W   = 32;
  localparam int LAYER_W  = 5;
  localparam int KEY_ID_W = 11;
  localparam int CNT_W    = 4;
  localparam int DEB_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_COLS     = 2'd2,
    CFG_DEBOUNCE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // What one column lane found for the addressed row.
  typedef struct packed {
    logic evt;
    logic pressed;
    logic stable;
  } lane_res_t;

  // Row-level data handed to the merge stage.
  typedef struct packed {
    logic                load;
    logic [KEY_ID_W-1:0] base_id;
    logic                led_update;
    logic                led_on;
  } merge_load_t;

endpackage

// ===== src/kmds_if.sv =====
// Handshake channels of the key matrix debounce scanner: scanned-row input,
// result output and configuration write. Depends on kmds_pkg.
interface kmds_in_if import kmds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row;
  logic [COLBIT_W-1:0] col_pressed;
  logic [TIME_W-1:0]   now_ms;
  logic [LAYER_W-1:0]  layer;

  modport source (output valid, row, col_pressed, now_ms, layer, input ready);
  modport sink   (input valid, row, col_pressed, now_ms, layer, output ready);
endinterface

interface kmds_out_if import kmds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [KEY_ID_W-1:0] key_id;
  logic                pressed;
  logic                led_update;
  logic                led_on;
  logic                last;

  modport source (output valid, kind, key_id, pressed, led_update, led_on, last,
                  input ready);
  modport sink   (input valid, kind, key_id, pressed, led_update, led_on, last,
                  output ready);
endinterface

interface kmds_cfg_if import kmds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DEB_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/key_matrix_debounce_scanner.sv =====
// Top level of the key matrix debounce scanner: configuration registers,
// item registers, controller, column lanes and merge stage.
// Depends on kmds_pkg, kmds_if, kmds_lane and kmds_merge.
//
// Usage:
//   in_ch  : one beat per scanned matrix row (row, col_pressed, now_ms, layer).
//   out_ch : result beats. A processed row gives zero to eight key events
//            (kind 0) in ascending column order, then one row-done beat
//            (kind 1, last 1). The row-done beat of the last active row
//            carries led_update and the any-key-pressed flag in led_on.
//   cfg_ch : register writes (enable, row_count, col_count, debounce_ms),
//            always ready; write only while no row is in flight.
// Timing: one row at a time. After the input beat is taken, the EVAL state
//   runs all column lanes in parallel on the addressed row; the first result
//   beat is shown in the cycle after, in EMIT. A row that is out of range,
//   or arrives while the scanner is disabled or col_count is zero, is taken
//   and dropped in its accept cycle. The single result port sets the rate.
// Stall: while out_ch.ready is low the current beat holds and in_ch.ready
//   stays low until the row-done beat is taken.
// Reset (rst_n low, synchronous): all keys released, flag cleared, registers
//   back to enable=1, row_count=0, col_count=0, debounce_ms=50.
module key_matrix_debounce_scanner import kmds_pkg::*; #(
  parameter int ROWS_MAX   = ROWS_MAX_D,
  parameter int COLS_MAX   = COLS_MAX_D,
  parameter int LAYERS_MAX = LAYERS_MAX_D
) (
  input  logic        clk,
  input  logic        rst_n,
  kmds_in_if.sink     in_ch,
  kmds_out_if.source  out_ch,
  kmds_cfg_if.sink    cfg_ch
);

  // Lanes that can ever be active: the column field is eight bits wide.
  localparam int NL = (COLS_MAX < COLBIT_W) ? COLS_MAX : COLBIT_W;
  localparam int RW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int BASE_W = 14;

  // ---------------- configuration registers ----------------
  logic             enable_r;
  logic [CNT_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [DEB_W-1:0] deb_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      rows_cfg_r <= '0;
      cols_cfg_r <= '0;
      deb_r      <= DEBOUNCE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_ENABLE:   enable_r   <= cfg_ch.data[0];
        CFG_ROWS:     rows_cfg_r <= cfg_ch.data[CNT_W-1:0];
        CFG_COLS:     cols_cfg_r <= cfg_ch.data[CNT_W-1:0];
        CFG_DEBOUNCE: deb_r      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ---------------- input qualification ----------------
  logic [4:0]         rows_eff;
  logic [CNT_W-1:0]   cols_eff;
  logic               active;
  logic               last_row;
  logic [LAYER_W-1:0] lay_c;
  logic [7:0]         rc;

  always_comb begin
    rows_eff = (32'(rows_cfg_r) > ROWS_MAX) ? 5'(ROWS_MAX) : {1'b0, rows_cfg_r};
    cols_eff = (32'(cols_cfg_r) > NL) ? CNT_W'(NL) : cols_cfg_r;
    active   = enable_r && (rows_cfg_r != '0) && (cols_cfg_r != '0) &&
               ({2'b0, in_ch.row} < rows_eff);
    last_row = ({2'b0, in_ch.row} == rows_eff - 5'd1);
    // clamp the layer to 1..LAYERS_MAX
    lay_c = (in_ch.layer == '0) ? LAYER_W'(1) : in_ch.layer;
    if (32'(lay_c) > LAYERS_MAX) lay_c = LAYER_W'(LAYERS_MAX);
    rc = 8'({3'b0, rows_eff} * {4'b0, cols_eff});
  end

  // ---------------- controller ----------------
  state_t state_r, state_nxt;
  logic   in_beat;
  logic   lanes_upd;
  logic   merge_ld;
  logic   emit;
  logic   done;

  assign in_beat = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_beat && active) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_EMIT;
      ST_EMIT: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    lanes_upd   = 1'b0;
    merge_ld    = 1'b0;
    emit        = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_EVAL: begin
        lanes_upd = 1'b1;
        merge_ld  = 1'b1;
      end
      ST_EMIT: emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- item registers ----------------
  logic [ROW_W-1:0]    row_r;
  logic [COLBIT_W-1:0] bits_r;
  logic [TIME_W-1:0]   now_r;
  logic [LAYER_W-1:0]  lm1_r;
  logic [CNT_W-1:0]    cols_r;
  logic                last_row_r;
  logic [7:0]          rc_r;

  always_ff @(posedge clk) begin
    if (in_beat && active) begin
      row_r      <= in_ch.row;
      bits_r     <= in_ch.col_pressed;
      now_r      <= in_ch.now_ms;
      lm1_r      <= lay_c - LAYER_W'(1);
      cols_r     <= cols_eff;
      last_row_r <= last_row;
      rc_r       <= rc;
    end
  end

  // ---------------- column lanes ----------------
  logic [NL-1:0] colmask;
  lane_res_t     lane_res [NL];
  logic [NL-1:0] evt_vec, press_vec, stable_vec;

  for (genvar c = 0; c < NL; c++) begin : g_lane
    assign colmask[c] = (32'(cols_r) > c);

    kmds_lane #(.ROWS_MAX(ROWS_MAX)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (lanes_upd && colmask[c]),
      .row_idx  (RW'(row_r)),
      .phys     (bits_r[c]),
      .now_ms   (now_r),
      .debounce (deb_r),
      .res      (lane_res[c])
    );

    assign evt_vec[c]    = lane_res[c].evt && colmask[c];
    assign press_vec[c]  = lane_res[c].pressed;
    assign stable_vec[c] = lane_res[c].stable && colmask[c];
  end

  // ---------------- any-pressed flag and row summary ----------------
  logic        any_r, any_nxt;
  logic [BASE_W-1:0] base_full;
  merge_load_t ld;

  always_comb begin
    // clear on row 0, then fold in every active key that is stably pressed
    any_nxt   = ((row_r == '0) ? 1'b0 : any_r) | (|stable_vec);
    base_full = BASE_W'(row_r) * BASE_W'(cols_r) + BASE_W'(lm1_r) * BASE_W'(rc_r)
                + BASE_W'(1);
    ld.load       = merge_ld;
    ld.base_id    = base_full[KEY_ID_W-1:0];
    ld.led_update = last_row_r;
    ld.led_on     = last_row_r && any_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (lanes_upd) begin
      any_r <= any_nxt;
    end
  end

  // ---------------- merge and result port ----------------
  kmds_merge #(.NL(NL)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .evt_vec   (evt_vec),
    .press_vec (press_vec),
    .emit      (emit),
    .done      (done),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/kmds_lane.sv =====
// One column lane: raw, stable and change-time state for every row of its
// column, plus the debounce decision. Depends on kmds_pkg.
module kmds_lane import kmds_pkg::*; #(
  parameter int ROWS_MAX = ROWS_MAX_D,
  localparam int RW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic [RW-1:0]     row_idx,
  input  logic              phys,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [DEB_W-1:0]  debounce,
  output lane_res_t         res
);

  logic [ROWS_MAX-1:0] raw_r;
  logic [ROWS_MAX-1:0] stable_r;
  logic [TIME_W-1:0]   time_r [ROWS_MAX];

  logic              raw_cur, stable_cur;
  logic [TIME_W-1:0] time_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              evt;

  always_comb begin
    raw_cur    = raw_r[row_idx];
    stable_cur = stable_r[row_idx];
    time_nxt   = (phys != raw_cur) ? now_ms : time_r[row_idx];
    elapsed    = now_ms - time_nxt;
    evt        = (elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce}) && (phys != stable_cur);
    res.evt     = evt;
    res.pressed = phys;
    res.stable  = evt ? phys : stable_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '0;
      stable_r <= '0;
    end else if (upd) begin
      raw_r[row_idx]    <= phys;
      stable_r[row_idx] <= res.stable;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      time_r[row_idx] <= time_nxt;
    end
  end

endmodule

// ===== src/kmds_merge.sv =====
// Merge stage: holds the event flags of all lanes for one row and sends
// them as beats in column order, then the row-done beat. Depends on kmds_pkg.
module kmds_merge import kmds_pkg::*; #(
  parameter int NL = 8,
  localparam int LW = (NL > 1) ? $clog2(NL) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  merge_load_t     ld,
  input  logic [NL-1:0]   evt_vec,
  input  logic [NL-1:0]   press_vec,
  input  logic            emit,
  output logic            done,
  kmds_out_if.source      out_ch
);

  logic [NL-1:0]       mask_r, mask_nxt;
  logic [NL-1:0]       press_r;
  logic [KEY_ID_W-1:0] base_r;
  logic                ledu_r, ledon_r;

  logic [LW-1:0] sel;
  logic          has_evt;
  logic          beat;

  always_comb begin
    sel = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = LW'(i);
    end
  end

  assign has_evt = |mask_r;
  assign beat    = emit && out_ch.ready;
  assign done    = beat && !has_evt;

  assign out_ch.valid      = emit;
  assign out_ch.kind       = !has_evt;
  assign out_ch.key_id     = has_evt ? base_r + KEY_ID_W'(sel) : '0;
  assign out_ch.pressed    = has_evt && press_r[sel];
  assign out_ch.led_update = !has_evt && ledu_r;
  assign out_ch.led_on     = !has_evt && ledon_r;
  assign out_ch.last       = !has_evt;

  always_comb begin
    mask_nxt = mask_r;
    if (ld.load) begin
      mask_nxt = evt_vec;
    end else if (beat && has_evt) begin
      mask_nxt[sel] = 1'b0;  // drop the event just sent
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      press_r <= press_vec;
      base_r  <= ld.base_id;
      ledu_r  <= ld.led_update;
      ledon_r <= ld.led_on;
    end
  end

endmodule

// ===== src/kmds_checker.sv =====
// Port-level checks for the key matrix debounce scanner, attached by bind.
// Depends on kmds_pkg and key_matrix_debounce_scanner.
module kmds_checker import kmds_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_kind,
  input logic [KEY_ID_W-1:0] out_key_id,
  input logic                out_pressed,
  input logic                out_led_update,
  input logic                out_led_on,
  input logic                out_last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_key_id) && $stable(out_pressed) && $stable(out_last))
    else $error("stalled result beat changed");

  // No row is taken while results of the previous one are pending.
  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("row accepted while results pending");

  // An event beat is always followed by more beats of the same row.
  a_evt_then_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("row ended without row-done beat");

  // Field usage by kind.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == out_last) &&
    (out_kind ? (out_key_id == '0 && !out_pressed) :
                (out_key_id != '0 && !out_led_update && !out_led_on)) &&
    (!out_led_on || out_led_update))
    else $error("result fields inconsistent with kind");

endmodule

bind key_matrix_debounce_scanner kmds_checker u_kmds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_key_id     (out_ch.key_id),
  .out_pressed    (out_ch.pressed),
  .out_led_update (out_ch.led_update),
  .out_led_on     (out_ch.led_on),
  .out_last       (out_ch.last)
);

// ===== tb/key_matrix_debounce_scanner_tb.sv =====
// Self-checking testbench for key_matrix_debounce_scanner: a scoreboard keeps
// per-key debounce state and checks every result beat against it.
// Depends on kmds_pkg, kmds_if and the key_matrix_debounce_scanner RTL.
module key_matrix_debounce_scanner_tb import kmds_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  KEYS          = ROWS_MAX_D * COLS_MAX_D;
  localparam logic KIND_KEY     = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  // One scanned row as driven on in_ch.
  typedef struct {
    logic [ROW_W-1:0]    row;
    logic [COLBIT_W-1:0] cols;
    logic [TIME_W-1:0]   stamp;
    logic [LAYER_W-1:0]  layer;
  } scan_row_t;

  // One beat on out_ch.
  typedef struct packed {
    logic                kind;
    logic [KEY_ID_W-1:0] key_id;
    logic                pressed;
    logic                led_update;
    logic                led_on;
    logic                last;
  } scan_result_t;

  logic clk;
  logic rst_n;

  kmds_in_if  in_ch ();
  kmds_out_if out_ch ();
  kmds_cfg_if cfg_ch ();

  key_matrix_debounce_scanner i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register shadow and per-key debounce state of the scoreboard.
  logic                en_q;
  logic [CNT_W-1:0]    rows_q;
  logic [CNT_W-1:0]    cols_q;
  logic [DEB_W-1:0]    hold_q;
  logic                raw_q    [KEYS];
  logic                stable_q [KEYS];
  logic [TIME_W-1:0]   changed_at [KEYS];
  logic                any_down;

  scan_row_t    rows_pending [$];   // rows still to be offered on in_ch
  scan_result_t beats_due    [$];   // result beats the block still owes
  int           mismatches;

  // Physical key matrix that the random scans read from.
  logic [COLBIT_W-1:0] held_keys [ROWS_MAX_D];

  // Sender burst/gap bookkeeping and the beat flag from the last rising edge.
  int burst_left;
  int gap_left;
  bit in_beat;
  int stall_clock;

  //--------------------------------------------------------------------------
  // Scoreboard: debounce one accepted row and queue the beats it causes.
  //--------------------------------------------------------------------------
  function automatic void debounce_row(scan_row_t it);
    int unsigned  rows;
    int unsigned  cols;
    int unsigned  lay;
    int unsigned  idx;
    int unsigned  c;
    logic         phys;
    logic [TIME_W-1:0] elapsed;
    scan_result_t r;
    // Disabled block or out-of-range row: drop silently, keep all state.
    if (!en_q || rows_q == 0 || cols_q == 0) return;
    rows = (rows_q > ROWS_MAX_D) ? ROWS_MAX_D : rows_q;
    cols = (cols_q > COLS_MAX_D) ? COLS_MAX_D : cols_q;
    if (cols > COLBIT_W) cols = COLBIT_W;
    if (it.row >= rows) return;
    // Clamp the layer into 1..LAYERS_MAX.
    lay = it.layer;
    if (lay < 1) lay = 1;
    if (lay > LAYERS_MAX_D) lay = LAYERS_MAX_D;
    // A new full scan starts on row 0.
    if (it.row == 0) any_down = 1'b0;
    for (c = 0; c < cols; c++) begin
      idx  = it.row * COLS_MAX_D + c;
      phys = it.cols[c];
      if (phys != raw_q[idx]) begin
        raw_q[idx]      = phys;
        changed_at[idx] = it.stamp;
      end
      elapsed = it.stamp - changed_at[idx];
      if (elapsed > TIME_W'(hold_q) && raw_q[idx] != stable_q[idx]) begin
        stable_q[idx] = raw_q[idx];
        r            = '0;
        r.kind       = KIND_KEY;
        r.key_id     = KEY_ID_W'(it.row * cols + c + 1 + (lay - 1) * rows * cols);
        r.pressed    = stable_q[idx];
        beats_due.push_back(r);
      end
      if (stable_q[idx]) any_down = 1'b1;
    end
    // Row-done beat closes every processed row.
    r            = '0;
    r.kind       = KIND_ROW_END;
    r.led_update = (it.row == rows - 1);
    r.led_on     = r.led_update && any_down;
    r.last       = 1'b1;
    beats_due.push_back(r);
  endfunction

  function automatic void note_mismatch(bit unexpected, scan_result_t want,
                                        scan_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected)
        $display("%0t: result beat with nothing due: kind=%0d id=%0d pr=%0d upd=%0d led=%0d last=%0d",
                 $time, got.kind, got.key_id, got.pressed, got.led_update,
                 got.led_on, got.last);
      else
        $display("%0t: beat differs: exp kind=%0d id=%0d pr=%0d upd=%0d led=%0d last=%0d",
                 $time, want.kind, want.key_id, want.pressed, want.led_update,
                 want.led_on, want.last);
      if (!unexpected)
        $display("%0t:               got kind=%0d id=%0d pr=%0d upd=%0d led=%0d last=%0d",
                 $time, got.kind, got.key_id, got.pressed, got.led_update,
                 got.led_on, got.last);
    end
  endfunction

  //--------------------------------------------------------------------------
  // Clock and reset.
  //--------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Rising edge: take the accepted row into the scoreboard first, then check
  // any result beat against the oldest one due.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    scan_row_t    it;
    in_beat = rst_n && in_ch.valid && in_ch.ready;
    if (in_beat) begin
      it.row   = in_ch.row;
      it.cols  = in_ch.col_pressed;
      it.stamp = in_ch.now_ms;
      it.layer = in_ch.layer;
      debounce_row(it);
      void'(rows_pending.pop_front());
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind       = out_ch.kind;
      got.key_id     = out_ch.key_id;
      got.pressed    = out_ch.pressed;
      got.led_update = out_ch.led_update;
      got.led_on     = out_ch.led_on;
      got.last       = out_ch.last;
      if (beats_due.size() == 0) begin
        note_mismatch(1'b1, '0, got);
      end else begin
        want = beats_due.pop_front();
        if (got != want) note_mismatch(1'b0, want, got);
      end
    end
  end

  //--------------------------------------------------------------------------
  // Falling edge: row driver. Hold the current row until it is taken, then
  // offer the next one unless a gap between bursts is running.
  //--------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (rows_pending.size() > 0) begin
        in_ch.valid       <= 1'b1;
        in_ch.row         <= rows_pending[0].row;
        in_ch.col_pressed <= rows_pending[0].cols;
        in_ch.now_ms      <= rows_pending[0].stamp;
        in_ch.layer       <= rows_pending[0].layer;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: rotate between always ready, coin-flip stalls and a
  // sparse one-in-four pattern so stalls hit every phase of a row.
  always @(negedge clk) begin
    stall_clock++;
    case ((stall_clock / 97) % 3)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (stall_clock % 4 == 0);
    endcase
  end

  //--------------------------------------------------------------------------
  // Stimulus helpers.
  //--------------------------------------------------------------------------
  task automatic add_row(logic [ROW_W-1:0] row, logic [COLBIT_W-1:0] cols,
                         logic [TIME_W-1:0] stamp, logic [LAYER_W-1:0] layer);
    scan_row_t it;
    it.row   = row;
    it.cols  = cols;
    it.stamp = stamp;
    it.layer = layer;
    rows_pending.push_back(it);
  endtask

  // Drain: wait until every row is taken and every beat seen, then let the
  // clock run on for a dropped row still in its accept cycle.
  task automatic drain();
    while (rows_pending.size() != 0 || beats_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write one register; the shadow copy follows on the accepting edge.
  task automatic write_reg(cfg_idx_t idx, logic [DEB_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ENABLE:   en_q   = val[0];
      CFG_ROWS:     rows_q = val[CNT_W-1:0];
      CFG_COLS:     cols_q = val[CNT_W-1:0];
      CFG_DEBOUNCE: hold_q = val;
      default:      ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Row or column count: mostly in range, sometimes zero or oversized.
  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(9, 15);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // One random phase: new settings, then full scans over the held matrix
  // with time advancing around the debounce window, plus some noise rows.
  task automatic run_phase(int n_items);
    int          span;
    int          hold_ms;
    int          cnt;
    int          r;
    int          rows;
    logic [TIME_W-1:0]  stamp;
    logic [LAYER_W-1:0] layer;
    case ($urandom_range(0, 5))
      0:       hold_ms = 0;
      1:       hold_ms = $urandom_range(1, 4);
      2:       hold_ms = 50;
      3:       hold_ms = $urandom_range(0, 300);
      4:       hold_ms = 65535;
      default: hold_ms = $urandom_range(0, 65535);
    endcase
    rows = pick_count();
    write_reg(CFG_ENABLE, DEB_W'($urandom_range(0, 7) != 0));
    write_reg(CFG_ROWS, DEB_W'(rows));
    write_reg(CFG_COLS, DEB_W'(pick_count()));
    write_reg(CFG_DEBOUNCE, DEB_W'(hold_ms));
    span = (rows == 0) ? 1 : (rows > ROWS_MAX_D ? ROWS_MAX_D : rows);
    // Start anywhere, or just below the wrap point of the timestamp.
    if ($urandom_range(0, 2) == 0)
      stamp = 32'hFFFF_FFFF - $urandom_range(0, 4 * hold_ms + 1000);
    else
      stamp = $urandom();
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 4) != 0) layer = LAYER_W'($urandom_range(1, 16));
      else if ($urandom_range(0, 1) == 0) layer = 0;
      else layer = LAYER_W'($urandom_range(17, 31));
      for (r = 0; r < span && cnt < n_items; r++) begin
        if ($urandom_range(0, 7) == 0)
          add_row(ROW_W'($urandom_range(0, 7)), COLBIT_W'($urandom()), $urandom(),
                  LAYER_W'($urandom_range(0, 31)));
        else
          add_row(ROW_W'(r), held_keys[r], stamp, layer);
        cnt++;
        stamp += $urandom_range(0, (2 * hold_ms) / span + 2);
      end
      // Press or release keys between scans.
      if ($urandom_range(0, 1) == 0)
        held_keys[ROW_W'($urandom_range(0, 7))][ROW_W'($urandom_range(0, 7))] ^= 1'b1;
      if ($urandom_range(0, 5) == 0)
        held_keys[ROW_W'($urandom_range(0, 7))] = COLBIT_W'($urandom());
    end
    drain();
  endtask

  //--------------------------------------------------------------------------
  // Main sequence.
  //--------------------------------------------------------------------------
  initial begin
    int i;
    in_ch.valid       = 1'b0;
    in_ch.row         = '0;
    in_ch.col_pressed = '0;
    in_ch.now_ms      = '0;
    in_ch.layer       = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_ENABLE;
    cfg_ch.data       = '0;
    mismatches        = 0;
    burst_left        = 0;
    gap_left          = 0;
    stall_clock       = 0;
    in_beat           = 1'b0;

    // Scoreboard starts from the reset state of the block.
    en_q     = 1'b1;
    rows_q   = '0;
    cols_q   = '0;
    hold_q   = DEBOUNCE_RST;
    any_down = 1'b0;
    for (i = 0; i < KEYS; i++) begin
      raw_q[i]      = 1'b0;
      stable_q[i]   = 1'b0;
      changed_at[i] = '0;
    end
    for (i = 0; i < ROWS_MAX_D; i++) held_keys[i] = COLBIT_W'($urandom());

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings have no rows or columns: the row must vanish.
    add_row(0, 8'hFF, 10, 1);
    drain();

    // Full matrix, zero debounce: presses settle one ms after they appear.
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_ROWS, 8);
    write_reg(CFG_COLS, 8);
    write_reg(CFG_DEBOUNCE, 0);
    add_row(0, 8'hFF, 100, 1);
    add_row(7, 8'hFF, 100, 16);
    add_row(0, 8'hFF, 101, 16);          // top layer, eight presses
    add_row(7, 8'hFF, 101, 0);           // layer zero counts as one
    add_row(7, 8'h00, 102, 31);
    add_row(7, 8'h00, 103, 17);          // layer above max, highest key id
    add_row(0, 8'h00, 32'hFFFF_FFFF, 1); // row zero clears the pressed flag
    add_row(0, 8'h00, 0, 1);             // elapsed time across the wrap
    drain();

    // Oversized counts saturate; longest debounce must be strictly exceeded.
    write_reg(CFG_ROWS, 15);
    write_reg(CFG_COLS, 12);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    add_row(7, 8'h81, 5, 2);
    add_row(7, 8'h81, 65540, 2);
    add_row(7, 8'h81, 65541, 2);
    drain();

    // Small matrix: out-of-range rows drop, unused columns are ignored.
    write_reg(CFG_ROWS, 3);
    write_reg(CFG_COLS, 2);
    write_reg(CFG_DEBOUNCE, 50);
    add_row(3, 8'hFF, 0, 1);
    add_row(5, 8'hFF, 0, 1);
    add_row(0, 8'hFC, 70000, 1);
    add_row(1, 8'h03, 70000, 1);
    add_row(2, 8'h01, 70000, 1);
    add_row(0, 8'hFC, 70100, 1);
    add_row(1, 8'h03, 70100, 3);
    add_row(2, 8'h01, 70100, 3);         // last row reports the LED
    drain();

    // Disabled block and zero columns: nothing comes out.
    write_reg(CFG_ENABLE, 0);
    add_row(0, 8'hFF, 1, 1);
    drain();
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_COLS, 0);
    add_row(0, 8'hFF, 2, 1);
    drain();

    // Random phases over varied settings.
    for (i = 0; i < 7; i++) run_phase(16);

    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
